// ===== rtl/tfn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tfn_pkg;

  localparam int COORD_WIDTH_DEF  = 32;
  localparam int NORMAL_WIDTH_DEF = 16;

  // scaled cross magnitudes, their sum of squares and its root
  localparam int MAG_W      = 30;
  localparam int SUM_W      = 2 * MAG_W + 2;
  localparam int ROOT_W     = MAG_W + 1;
  localparam int SQRT_STEPS = SUM_W / 2;

  typedef logic [MAG_W-1:0]  mag_t;
  typedef logic [SUM_W-1:0]  sum_t;
  typedef logic [ROOT_W-1:0] root_t;

  typedef struct packed {
    logic [2:0] neg;
    logic       deg;
  } flags_t;

  typedef struct packed {
    mag_t [2:0] m;
    flags_t     fl;
  } sq_side_t;

endpackage

`default_nettype wire

// ===== rtl/tfn_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tfn_in_if import tfn_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] p1_x;
  logic signed [COORD_WIDTH-1:0] p1_y;
  logic signed [COORD_WIDTH-1:0] p1_z;
  logic signed [COORD_WIDTH-1:0] p2_x;
  logic signed [COORD_WIDTH-1:0] p2_y;
  logic signed [COORD_WIDTH-1:0] p2_z;
  logic signed [COORD_WIDTH-1:0] p3_x;
  logic signed [COORD_WIDTH-1:0] p3_y;
  logic signed [COORD_WIDTH-1:0] p3_z;

  modport source (
    output valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
    input  ready
  );
  modport sink (
    input  valid, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/tfn_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tfn_out_if import tfn_pkg::*; #(
  parameter int NORMAL_WIDTH = NORMAL_WIDTH_DEF
) ();
  logic                           valid;
  logic                           ready;
  logic signed [NORMAL_WIDTH-1:0] norm_x;
  logic signed [NORMAL_WIDTH-1:0] norm_y;
  logic signed [NORMAL_WIDTH-1:0] norm_z;
  logic                           degenerate;

  modport source (
    output valid, norm_x, norm_y, norm_z, degenerate,
    input  ready
  );
  modport sink (
    input  valid, norm_x, norm_y, norm_z, degenerate,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/triangle_face_normal_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Beat
// in_ch    in   p1_x p1_y p1_z p2_x p2_y p2_z p3_x p3_y p3_z (signed Q16.16)
// out_ch   out  norm_x norm_y norm_z (signed Q1.F, F = NORMAL_WIDTH-2), degenerate
//
// One triangle per cycle while the output is not stalled.
// Depth is set by the 31-stage square root and the NORMAL_WIDTH-1 divider stages.
// Reset clears only the stage valid bits; data registers carry no reset.
// Every stage holds while the stage after it is full and stalled, so bubbles
// close up and the input keeps taking beats while a result waits at the output.
module triangle_face_normal_unit import tfn_pkg::*; #(
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
  parameter int NORMAL_WIDTH = NORMAL_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tfn_in_if.sink    in_ch,
  tfn_out_if.source out_ch
);

  localparam int EDGE_W  = COORD_WIDTH + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int BLEN_W  = $clog2(CROSS_W + 1);
  localparam int FRAC    = NORMAL_WIDTH - 2;
  localparam int QUO_W   = FRAC + 1;
  localparam int NUM_W   = MAG_W + QUO_W;
  localparam int SQ0     = 8;
  localparam int PREP    = SQ0 + SQRT_STEPS;
  localparam int DV0     = PREP + 1;
  localparam int OUTS    = DV0 + QUO_W;
  localparam int NS      = OUTS + 1;

  localparam logic [QUO_W-1:0]             Q_ONE   = QUO_W'(1) << FRAC;
  localparam logic signed [NORMAL_WIDTH-1:0] N_ONE = NORMAL_WIDTH'(1) << FRAC;
  localparam root_t                          LEN_MIN = root_t'(1) << (MAG_W - 1);

  // stage valid bits and advance chain
  logic [NS-1:0] v_r;
  logic [NS-1:0] v_nxt;
  logic [NS:0]   adv;

  assign adv[NS] = out_ch.ready;
  genvar g;
  generate
    for (g = 0; g < NS; g++) begin : g_adv
      assign adv[g] = !v_r[g] || adv[g+1];
    end
  endgenerate

  assign v_nxt       = {v_r[NS-2:0], in_ch.valid};
  // take no beat while reset holds the valid bits clear
  assign in_ch.ready = rst_n && adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= (adv[NS-1:0] & v_nxt) | (~adv[NS-1:0] & v_r);
    end
  end

  // stage 0: edges
  logic signed [EDGE_W-1:0] a0_r [3];
  logic signed [EDGE_W-1:0] b0_r [3];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      a0_r[0] <= EDGE_W'(in_ch.p3_x) - EDGE_W'(in_ch.p1_x);
      a0_r[1] <= EDGE_W'(in_ch.p3_y) - EDGE_W'(in_ch.p1_y);
      a0_r[2] <= EDGE_W'(in_ch.p3_z) - EDGE_W'(in_ch.p1_z);
      b0_r[0] <= EDGE_W'(in_ch.p2_x) - EDGE_W'(in_ch.p1_x);
      b0_r[1] <= EDGE_W'(in_ch.p2_y) - EDGE_W'(in_ch.p1_y);
      b0_r[2] <= EDGE_W'(in_ch.p2_z) - EDGE_W'(in_ch.p1_z);
    end
  end

  // stage 1: partial products
  logic signed [PROD_W-1:0] pr1_r [6];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      pr1_r[0] <= a0_r[1] * b0_r[2];
      pr1_r[1] <= b0_r[1] * a0_r[2];
      pr1_r[2] <= b0_r[0] * a0_r[2];
      pr1_r[3] <= a0_r[0] * b0_r[2];
      pr1_r[4] <= a0_r[0] * b0_r[1];
      pr1_r[5] <= b0_r[0] * a0_r[1];
    end
  end

  // stage 2: cross product
  logic signed [CROSS_W-1:0] cr2_r [3];

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int i = 0; i < 3; i++) begin
        cr2_r[i] <= CROSS_W'(pr1_r[2*i]) - CROSS_W'(pr1_r[2*i+1]);
      end
    end
  end

  // stage 3: sign and magnitude
  logic [CROSS_W-1:0] mg3_r [3];
  logic [2:0]         ng3_r;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int i = 0; i < 3; i++) begin
        ng3_r[i] <= cr2_r[i][CROSS_W-1];
        mg3_r[i] <= cr2_r[i][CROSS_W-1] ? CROSS_W'(-cr2_r[i]) : CROSS_W'(cr2_r[i]);
      end
    end
  end

  // stage 4: bit length of the largest magnitude
  function automatic logic [BLEN_W-1:0] bit_len(input logic [CROSS_W-1:0] v);
    logic [BLEN_W-1:0] n;
    n = '0;
    for (int j = 0; j < CROSS_W; j++) begin
      if (v[j]) n = BLEN_W'(j + 1);
    end
    return n;
  endfunction

  logic [CROSS_W-1:0] mg4_r [3];
  logic [2:0]         ng4_r;
  logic [BLEN_W-1:0]  bl4_r;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      mg4_r <= mg3_r;
      ng4_r <= ng3_r;
      bl4_r <= bit_len(mg3_r[0] | mg3_r[1] | mg3_r[2]);
    end
  end

  // stage 5: normalize into MAG_W bits
  mag_t              m5_nxt [3];
  logic [BLEN_W-1:0] sh5;
  logic              down5;

  always_comb begin
    down5 = bl4_r > BLEN_W'(MAG_W);
    sh5   = down5 ? BLEN_W'(bl4_r - BLEN_W'(MAG_W)) : BLEN_W'(BLEN_W'(MAG_W) - bl4_r);
    for (int i = 0; i < 3; i++) begin
      m5_nxt[i] = down5 ? MAG_W'(mg4_r[i] >> sh5) : MAG_W'(mg4_r[i] << sh5);
    end
  end

  mag_t       m5_r [3];
  logic [2:0] ng5_r;
  logic       dg5_r;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      m5_r  <= m5_nxt;
      ng5_r <= ng4_r;
      dg5_r <= bl4_r == '0;
    end
  end

  // stage 6: squares
  logic [2*MAG_W-1:0] sq6_r [3];
  mag_t               m6_r  [3];
  logic [2:0]         ng6_r;
  logic               dg6_r;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      for (int i = 0; i < 3; i++) begin
        sq6_r[i] <= m5_r[i] * m5_r[i];
      end
      m6_r  <= m5_r;
      ng6_r <= ng5_r;
      dg6_r <= dg5_r;
    end
  end

  // stage 7: sum of squares
  sum_t       s7_r;
  mag_t       m7_r [3];
  logic [2:0] ng7_r;
  logic       dg7_r;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      s7_r  <= SUM_W'(sq6_r[0]) + SUM_W'(sq6_r[1]) + SUM_W'(sq6_r[2]);
      m7_r  <= m6_r;
      ng7_r <= ng6_r;
      dg7_r <= dg6_r;
    end
  end

  // square root
  sq_side_t sq_side_in;
  sq_side_t sq_side_out;
  root_t    root_q;

  always_comb begin
    sq_side_in.m[0]   = m7_r[0];
    sq_side_in.m[1]   = m7_r[1];
    sq_side_in.m[2]   = m7_r[2];
    sq_side_in.fl.neg = ng7_r;
    sq_side_in.fl.deg = dg7_r;
  end

  tfn_isqrt u_isqrt (
    .clk      (clk),
    .en       (adv[SQ0 +: SQRT_STEPS]),
    .s_in     (s7_r),
    .side_in  (sq_side_in),
    .root     (root_q),
    .side_out (sq_side_out)
  );

  // prep: numerator with half the divisor added for rounding
  logic [NUM_W-1:0] num_r [3];
  root_t            len_r;
  flags_t           flp_r;

  always_ff @(posedge clk) begin
    if (adv[PREP]) begin
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= (NUM_W'(sq_side_out.m[i]) << FRAC) + NUM_W'(root_q >> 1);
      end
      len_r <= root_q;
      flp_r <= sq_side_out.fl;
    end
  end

  // divide
  logic [QUO_W-1:0] quo_q [3];
  flags_t           fld_q;

  tfn_div #(
    .QUO_W (QUO_W)
  ) u_div (
    .clk    (clk),
    .en     (adv[DV0 +: QUO_W]),
    .num_in (num_r),
    .len_in (len_r),
    .fl_in  (flp_r),
    .quo    (quo_q),
    .fl_out (fld_q)
  );

  // output register: clamp, apply sign, substitute the degenerate normal
  logic signed [NORMAL_WIDTH-1:0] nrm_nxt [3];
  logic signed [NORMAL_WIDTH-1:0] nrm_r   [3];
  logic                           dg_r;

  always_comb begin
    logic [QUO_W-1:0]        qc;
    logic [NORMAL_WIDTH-1:0] val;
    for (int i = 0; i < 3; i++) begin
      qc  = (quo_q[i] > Q_ONE) ? Q_ONE : quo_q[i];
      val = NORMAL_WIDTH'(qc);
      if (fld_q.deg) begin
        nrm_nxt[i] = (i == 1) ? N_ONE : '0;
      end else begin
        nrm_nxt[i] = fld_q.neg[i] ? $signed(-val) : $signed(val);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[OUTS]) begin
      nrm_r <= nrm_nxt;
      dg_r  <= fld_q.deg;
    end
  end

  assign out_ch.valid      = v_r[OUTS];
  assign out_ch.norm_x     = nrm_r[0];
  assign out_ch.norm_y     = nrm_r[1];
  assign out_ch.norm_z     = nrm_r[2];
  assign out_ch.degenerate = dg_r;

`ifndef SYNTHESIS
  a_deg_normal: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.degenerate |->
      out_ch.norm_x == '0 && out_ch.norm_y == N_ONE && out_ch.norm_z == '0)
    else $error("degenerate beat without the fixed normal");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |->
      out_ch.norm_x <= N_ONE && out_ch.norm_x >= -N_ONE &&
      out_ch.norm_z <= N_ONE && out_ch.norm_z >= -N_ONE)
    else $error("normal component beyond one");

  a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[PREP] && !flp_r.deg |-> len_r >= LEN_MIN)
    else $error("root of a normalized sum below 2^29");

  a_hold_stage: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[OUTS] && !adv[OUTS] |=> v_r[OUTS] && $stable(nrm_r[0]) && $stable(dg_r))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

// ===== rtl/tfn_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Pipelined integer square root, one result bit per stage.
module tfn_isqrt import tfn_pkg::*; (
  input  logic                  clk,
  input  logic [SQRT_STEPS-1:0] en,
  input  sum_t                  s_in,
  input  sq_side_t              side_in,
  output root_t                 root,
  output sq_side_t              side_out
);

  sum_t     rem_r  [SQRT_STEPS];
  sum_t     res_r  [SQRT_STEPS];
  sq_side_t side_r [SQRT_STEPS];

  genvar k;
  generate
    for (k = 0; k < SQRT_STEPS; k++) begin : g_step
      localparam sum_t BIT = sum_t'(1) << (SUM_W - 2 - 2 * k);
      sum_t           rem_in;
      sum_t           res_in;
      sq_side_t       side_k;
      logic [SUM_W:0] trial;

      if (k == 0) begin : g_first
        assign rem_in = s_in;
        assign res_in = '0;
        assign side_k = side_in;
      end else begin : g_next
        assign rem_in = rem_r[k-1];
        assign res_in = res_r[k-1];
        assign side_k = side_r[k-1];
      end

      assign trial = {1'b0, res_in} + {1'b0, BIT};

      always_ff @(posedge clk) begin
        if (en[k]) begin
          if ({1'b0, rem_in} >= trial) begin
            rem_r[k] <= rem_in - trial[SUM_W-1:0];
            res_r[k] <= (res_in >> 1) + BIT;
          end else begin
            rem_r[k] <= rem_in;
            res_r[k] <= res_in >> 1;
          end
          side_r[k] <= side_k;
        end
      end
    end
  endgenerate

  assign root     = res_r[SQRT_STEPS-1][ROOT_W-1:0];
  assign side_out = side_r[SQRT_STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/tfn_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Three-lane restoring divider, one quotient bit per stage.
// Numerator low bits shift out at the top while quotient bits shift in below.
module tfn_div import tfn_pkg::*; #(
  parameter int QUO_W = NORMAL_WIDTH_DEF - 1
) (
  input  logic                   clk,
  input  logic [QUO_W-1:0]       en,
  input  logic [MAG_W+QUO_W-1:0] num_in [3],
  input  root_t                  len_in,
  input  flags_t                 fl_in,
  output logic [QUO_W-1:0]       quo    [3],
  output flags_t                 fl_out
);

  localparam int NUM_W = MAG_W + QUO_W;

  root_t            rem_r [QUO_W][3];
  logic [QUO_W-1:0] lq_r  [QUO_W][3];
  root_t            len_r [QUO_W];
  flags_t           fl_r  [QUO_W];

  genvar k, i;
  generate
    for (k = 0; k < QUO_W; k++) begin : g_step
      root_t  len_k;
      flags_t fl_k;

      if (k == 0) begin : g_first
        assign len_k = len_in;
        assign fl_k  = fl_in;
      end else begin : g_next
        assign len_k = len_r[k-1];
        assign fl_k  = fl_r[k-1];
      end

      always_ff @(posedge clk) begin
        if (en[k]) begin
          len_r[k] <= len_k;
          fl_r[k]  <= fl_k;
        end
      end

      for (i = 0; i < 3; i++) begin : g_lane
        root_t             rem_in;
        logic [QUO_W-1:0]  lq_in;
        logic [ROOT_W:0]   trial;
        logic              ge;

        if (k == 0) begin : g_first
          assign rem_in = ROOT_W'(num_in[i][NUM_W-1:QUO_W]);
          assign lq_in  = num_in[i][QUO_W-1:0];
        end else begin : g_next
          assign rem_in = rem_r[k-1][i];
          assign lq_in  = lq_r[k-1][i];
        end

        assign trial = {rem_in, lq_in[QUO_W-1]};
        assign ge    = trial >= {1'b0, len_k};

        always_ff @(posedge clk) begin
          if (en[k]) begin
            rem_r[k][i] <= ge ? ROOT_W'(trial - {1'b0, len_k}) : ROOT_W'(trial);
            lq_r[k][i]  <= {lq_in[QUO_W-2:0], ge};
          end
        end
      end
    end

    for (i = 0; i < 3; i++) begin : g_out
      assign quo[i] = lq_r[QUO_W-1][i];
    end
  endgenerate

  assign fl_out = fl_r[QUO_W-1];

endmodule

`default_nettype wire

// ===== dv/tfn_normal_checker.sv =====
`timescale 1ns / 1ps

module tfn_normal_checker import tfn_pkg::*; #(
  parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
  parameter int NORMAL_WIDTH = NORMAL_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  tfn_in_if    in_ch,
  tfn_out_if   out_ch,
  output int   fail_count,
  output int   pending,
  output logic beat_seen
);

  localparam int FRAC = NORMAL_WIDTH - 2;

  typedef struct {
    logic signed [NORMAL_WIDTH-1:0] nx;
    logic signed [NORMAL_WIDTH-1:0] ny;
    logic signed [NORMAL_WIDTH-1:0] nz;
    logic                           deg;
  } normal_t;

  normal_t expected_normals[$];

  function automatic logic [63:0] floor_sqrt(logic [63:0] s);
    logic [63:0] res;
    logic [63:0] bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > s) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (s >= res + bit_v) begin
        s = s - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  function automatic normal_t face_normal(
    logic signed [COORD_WIDTH-1:0] c[9]);
    logic signed [COORD_WIDTH:0] ea[3], eb[3];
    logic signed [71:0] cr[3];
    logic        [71:0] mg[3];
    logic               ng[3];
    logic        [63:0] m[3];
    logic        [63:0] s, len, q, one;
    int blen;
    normal_t r;
    one = 64'd1 << FRAC;
    for (int i = 0; i < 3; i++) begin
      ea[i] = c[6+i] - c[i];
      eb[i] = c[3+i] - c[i];
    end
    cr[0] = 72'(ea[1]) * 72'(eb[2]) - 72'(eb[1]) * 72'(ea[2]);
    cr[1] = 72'(eb[0]) * 72'(ea[2]) - 72'(ea[0]) * 72'(eb[2]);
    cr[2] = 72'(ea[0]) * 72'(eb[1]) - 72'(eb[0]) * 72'(ea[1]);
    blen = 0;
    for (int i = 0; i < 3; i++) begin
      ng[i] = cr[i] < 0;
      mg[i] = ng[i] ? -cr[i] : cr[i];
      for (int k = 0; k < 72; k++) if (mg[i][k] && k + 1 > blen) blen = k + 1;
    end
    if (blen == 0) begin
      r.nx = 0; r.ny = NORMAL_WIDTH'(one); r.nz = 0; r.deg = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++)
      m[i] = blen > 30 ? 64'((mg[i] >> (blen - 30)) & 72'h3FFF_FFFF)
                       : 64'(mg[i] << (30 - blen));
    s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    len = floor_sqrt(s);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * one + (len >> 1)) / len;
      if (q > one) q = one;
      m[i] = ng[i] ? -q : q;
    end
    r.nx = NORMAL_WIDTH'(m[0]);
    r.ny = NORMAL_WIDTH'(m[1]);
    r.nz = NORMAL_WIDTH'(m[2]);
    r.deg = 1'b0;
    return r;
  endfunction

  assign beat_seen = (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready);

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    logic signed [COORD_WIDTH-1:0] c[9];
    normal_t e;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      c = '{in_ch.p1_x, in_ch.p1_y, in_ch.p1_z, in_ch.p2_x, in_ch.p2_y,
            in_ch.p2_z, in_ch.p3_x, in_ch.p3_y, in_ch.p3_z};
      expected_normals.insert(expected_normals.size(), face_normal(c));
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_normals.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("normal beat with none expected");
      end else begin
        e = expected_normals.pop_front();
        if (e.nx !== out_ch.norm_x || e.ny !== out_ch.norm_y ||
            e.nz !== out_ch.norm_z || e.deg !== out_ch.degenerate) begin
          fail_count++;
          if (fail_count <= 10)
            $display("normal mismatch: exp %0d %0d %0d deg %0b, got %0d %0d %0d deg %0b",
                     e.nx, e.ny, e.nz, e.deg, out_ch.norm_x, out_ch.norm_y,
                     out_ch.norm_z, out_ch.degenerate);
        end
      end
    end
    pending = expected_normals.size();
  end

endmodule

// ===== dv/tb_triangle_face_normal_unit.sv =====
`timescale 1ns / 1ps

module tb_triangle_face_normal_unit;
  import tfn_pkg::*;

  localparam int CW = COORD_WIDTH_DEF;
  localparam int DRAIN_CYCLES = 100;
  localparam int STALL_LIMIT = 5000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  logic beat_seen;
  logic hold_sink;
  logic quiet_sink;
  int   idle_cycles;

  tfn_in_if  #(.COORD_WIDTH(CW)) in_ch ();
  tfn_out_if out_ch ();

  triangle_face_normal_unit i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  tfn_normal_checker i_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .fail_count(fail_count), .pending(pending), .beat_seen(beat_seen));

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(CW-1){1'b0}}};
      1:       return {1'b0, {(CW-1){1'b1}}};
      2, 3:    return CW'($signed($urandom_range(0, 2000)) - 1000);
      4, 5:    return CW'($signed($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_triangle(logic [CW-1:0] c[9]);
    in_ch.valid <= 1'b1;
    {in_ch.p1_x, in_ch.p1_y, in_ch.p1_z, in_ch.p2_x, in_ch.p2_y,
     in_ch.p2_z, in_ch.p3_x, in_ch.p3_y, in_ch.p3_z} <=
      {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8]};
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Random gaps of the sender unless calm is set; the valid stays high across back-to-back beats.
  task automatic send_random(int count, bit calm);
    logic [CW-1:0] c[9];
    int shared;
    repeat (count) begin
      while (!calm && $urandom_range(0, 99) < 15) begin
        in_ch.valid <= 1'b0;
        @(negedge clk);
      end
      for (int i = 0; i < 9; i++) c[i] = rand_coord();
      shared = $urandom_range(0, 9);
      // collinear or repeated vertices
      if (shared == 0) for (int i = 0; i < 3; i++) c[3+i] = c[i];
      if (shared == 1) for (int i = 0; i < 3; i++) c[6+i] = c[3+i];
      if (shared == 2)
        for (int i = 0; i < 3; i++) c[6+i] = c[i] + 2 * (c[3+i] - c[i]);
      send_triangle(c);
    end
    in_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    logic [CW-1:0] c[9];
    logic [CW-1:0] mn, mx;
    mn = {1'b1, {(CW-1){1'b0}}};
    mx = ~mn;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    {in_ch.p1_x, in_ch.p1_y, in_ch.p1_z, in_ch.p2_x, in_ch.p2_y,
     in_ch.p2_z, in_ch.p3_x, in_ch.p3_y, in_ch.p3_z} = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // all zero, all equal: degenerate
    c = '{default: '0}; send_triangle(c);
    c = '{default: mx}; send_triangle(c);
    c = '{default: mn}; send_triangle(c);
    // axis-aligned unit triangles in each plane, both windings in the xy plane
    c = '{0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 0}; send_triangle(c);
    c = '{0, 0, 0, 0, 32'h10000, 0, 32'h10000, 0, 0}; send_triangle(c);
    c = '{0, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000}; send_triangle(c);
    c = '{0, 0, 0, 0, 0, 32'h10000, 32'h10000, 0, 0}; send_triangle(c);
    // smallest nonzero cross product
    c = '{0, 0, 0, 1, 0, 0, 0, 1, 0}; send_triangle(c);
    // extreme edges: widest cross product, with components of both signs
    c = '{mn, mn, mn, mx, mn, mn, mn, mx, mn}; send_triangle(c);
    c = '{mn, mn, mn, mx, mx, mn, mn, mx, mx}; send_triangle(c);
    c = '{mx, mx, mx, mn, mx, mx, mx, mn, mx}; send_triangle(c);
    c = '{mn, mx, mn, mx, mn, mx, mx, mx, mn}; send_triangle(c);
    c = '{mx, mn, mx, mn, mn, mn, mx, mx, mx}; send_triangle(c);
    // collinear
    c = '{0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h20000, 32'h20000, 32'h20000};
    send_triangle(c);
    c = '{1, 2, 3, 4, 5, 6, 7, 8, 9}; send_triangle(c);
    in_ch.valid <= 1'b0;
    wait_drained();

    send_random(200, 1'b1);
    // hold the sender until every result is back
    wait_drained();
    send_random(1000, 1'b0);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Hold off long enough to fill the pipeline while the sender keeps going.
  initial begin
    hold_sink = 1'b0;
    quiet_sink = 1'b1;
    wait (rst_n);
    repeat (400) @(negedge clk);
    hold_sink = 1'b1;
    repeat (300) @(negedge clk);
    hold_sink = 1'b0;
    repeat (300) @(negedge clk);
    quiet_sink = 1'b0;
  end

  initial out_ch.ready = 1'b0;
  always @(negedge clk)
    out_ch.ready <= !hold_sink && (quiet_sink || $urandom_range(0, 99) >= 15);

  always @(posedge clk) begin
    if (!rst_n || beat_seen) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
